@@ rtl/psd_pkg.sv @@
`timescale 1ns / 1ps
// psd_pkg: widths, constants, payload structs and controller/datapath command types
// for the population standard deviation block. No dependencies.
package psd_pkg;

  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned COUNT_W   = 17;
  localparam int unsigned SUM_W     = 33;
  localparam int unsigned SQ_W      = 31;
  localparam int unsigned SQSUM_W   = 47;
  localparam int unsigned MAG_W     = 32;
  localparam int unsigned PROD_W    = 2 * MAG_W;
  localparam int unsigned SPLIT     = 24;
  localparam int unsigned STD_W     = 31;

  localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(65536);
  localparam int unsigned FRAC_BITS = 16;

  // n*S2 - S1^2 stays below 2^62
  localparam int unsigned D_W       = 63;
  localparam int unsigned ROOT_W    = (D_W + 2 * FRAC_BITS + 1) / 2;
  localparam int unsigned X_W       = 2 * ROOT_W;
  localparam int unsigned SREM_W    = ROOT_W + 2;
  localparam int unsigned STEP_W    = $clog2(ROOT_W);

  localparam logic [STD_W-1:0] STD_MAX = '1;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } psd_in_t;

  typedef struct packed {
    logic [STD_W-1:0]   std_dev;
    logic [COUNT_W-1:0] sample_count;
    logic               overflowed;
  } psd_out_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_MSQ,
    OP_MLO,
    OP_MHI,
    OP_MADD,
    OP_DIFF,
    OP_SQRT,
    OP_DIV,
    OP_LOAD
  } psd_op_e;

  typedef struct packed {
    logic    take;
    psd_op_e op;
  } psd_cmd_t;

  typedef struct packed {
    logic step_done;
    logic out_free;
  } psd_sts_t;

endpackage

@@ rtl/psd_ctrl.sv @@
`timescale 1ns / 1ps
// psd_ctrl: sequencer for accumulation, final multiply phases, root and divide.
// Depends on psd_pkg.
module psd_ctrl
  import psd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_last_i,
  output logic     in_stall_o,
  output psd_cmd_t cmd_o,
  input  psd_sts_t sts_i
);

  localparam logic [3:0] ST_ACC   = 4'd0;
  localparam logic [3:0] ST_DRAIN = 4'd1;
  localparam logic [3:0] ST_MSQ   = 4'd2;
  localparam logic [3:0] ST_MLO   = 4'd3;
  localparam logic [3:0] ST_MHI   = 4'd4;
  localparam logic [3:0] ST_MADD  = 4'd5;
  localparam logic [3:0] ST_DIFF  = 4'd6;
  localparam logic [3:0] ST_SQRT  = 4'd7;
  localparam logic [3:0] ST_DIV   = 4'd8;
  localparam logic [3:0] ST_DONE  = 4'd9;

  logic [3:0] state_q, state_d;

  assign in_stall_o = (state_q != ST_ACC);

  always_comb begin
    state_d     = state_q;
    cmd_o.take  = 1'b0;
    cmd_o.op    = OP_NONE;
    unique case (state_q)
      ST_ACC: begin
        cmd_o.take = in_valid_i;
        if (in_valid_i && in_last_i) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: state_d = ST_MSQ;
      ST_MSQ: begin
        cmd_o.op = OP_MSQ;
        state_d  = ST_MLO;
      end
      ST_MLO: begin
        cmd_o.op = OP_MLO;
        state_d  = ST_MHI;
      end
      ST_MHI: begin
        cmd_o.op = OP_MHI;
        state_d  = ST_MADD;
      end
      ST_MADD: begin
        cmd_o.op = OP_MADD;
        state_d  = ST_DIFF;
      end
      ST_DIFF: begin
        cmd_o.op = OP_DIFF;
        state_d  = ST_SQRT;
      end
      ST_SQRT: begin
        cmd_o.op = OP_SQRT;
        if (sts_i.step_done) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.op = OP_DIV;
        if (sts_i.step_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.op = OP_LOAD;
          state_d  = ST_ACC;
        end
      end
      default: state_d = ST_ACC;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACC;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/psd_dp.sv @@
`timescale 1ns / 1ps
// psd_dp: input stage, accumulators, shared 32x32 multiplier, bit-serial root and
// divider, output register. Depends on psd_pkg.
module psd_dp
  import psd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  psd_in_t  in_data_i,
  input  psd_cmd_t cmd_i,
  output psd_sts_t sts_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output psd_out_t out_data_o
);

  // input stage: sample and its square
  logic signed [SAMPLE_W-1:0] smp;
  logic signed [2*SAMPLE_W-1:0] sq_full;
  logic                       p_valid_q;
  logic signed [SAMPLE_W-1:0] p_samp_q;
  logic [SQ_W-1:0]            p_sq_q;

  assign smp     = in_data_i.sample;
  assign sq_full = smp * smp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else begin
      p_valid_q <= cmd_i.take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      p_samp_q <= smp;
      p_sq_q   <= sq_full[SQ_W-1:0];
    end
  end

  // accumulators
  logic [COUNT_W-1:0]      total_q;
  logic signed [SUM_W-1:0] sum_q;
  logic [SQSUM_W-1:0]      sqsum_q;
  logic                    ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      sum_q   <= '0;
      sqsum_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      priority if (cmd_i.op == OP_LOAD) begin
        total_q <= '0;
        sum_q   <= '0;
        sqsum_q <= '0;
        ovf_q   <= 1'b0;
      end else if (p_valid_q) begin
        if (total_q < MAX_COUNT) begin
          total_q <= total_q + COUNT_W'(1);
          sum_q   <= sum_q + SUM_W'(p_samp_q);
          sqsum_q <= sqsum_q + SQSUM_W'(p_sq_q);
        end else begin
          ovf_q <= 1'b1;
        end
      end
    end
  end

  // shared multiplier, |S1|^2 then n*S2 in two halves
  logic [SUM_W-1:0]  sum_neg;
  logic [MAG_W-1:0]  mag;
  logic [MAG_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] prod_q, sqs_q, nsq_q, diff;
  logic [D_W-1:0]    dval;

  assign sum_neg = SUM_W'(-sum_q);
  assign mag     = sum_q[SUM_W-1] ? sum_neg[MAG_W-1:0] : sum_q[MAG_W-1:0];

  always_comb begin
    unique case (cmd_i.op)
      OP_MSQ: begin
        mul_a = mag;
        mul_b = mag;
      end
      OP_MLO: begin
        mul_a = MAG_W'(total_q);
        mul_b = MAG_W'(sqsum_q[SPLIT-1:0]);
      end
      OP_MHI: begin
        mul_a = MAG_W'(total_q);
        mul_b = MAG_W'(sqsum_q[SQSUM_W-1:SPLIT]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign diff = nsq_q - sqs_q;
  assign dval = (nsq_q >= sqs_q) ? diff[D_W-1:0] : '0;

  // root: two radicand bits per step; divide: one quotient bit per step,
  // quotient shifts into the root register
  logic [X_W-1:0]      x_q;
  logic [ROOT_W-1:0]   root_q;
  logic [SREM_W-1:0]   srem_q;
  logic [COUNT_W-1:0]  drem_q;
  logic [STEP_W-1:0]   step_q;
  logic [SREM_W+1:0]   srem_sh, trial, srem_sub;
  logic                s_ge;
  logic [COUNT_W:0]    drem_sh, drem_sub;
  logic                d_ge;
  logic                step_done;

  assign srem_sh  = {srem_q, x_q[X_W-1 -: 2]};
  assign trial    = (SREM_W + 2)'({root_q, 2'b01});
  assign s_ge     = (srem_sh >= trial);
  assign srem_sub = srem_sh - trial;

  assign drem_sh  = {drem_q, root_q[ROOT_W-1]};
  assign d_ge     = (drem_sh >= {1'b0, total_q});
  assign drem_sub = drem_sh - {1'b0, total_q};

  assign step_done = (step_q == STEP_W'(ROOT_W - 1));

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_MSQ: prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
      OP_MLO: begin
        sqs_q  <= prod_q;
        prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
      end
      OP_MHI: begin
        nsq_q  <= prod_q;
        prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
      end
      OP_MADD: nsq_q <= nsq_q + (prod_q << SPLIT);
      OP_DIFF: begin
        x_q    <= X_W'(dval) << (2 * FRAC_BITS);
        root_q <= '0;
        srem_q <= '0;
        drem_q <= '0;
      end
      OP_SQRT: begin
        x_q    <= x_q << 2;
        srem_q <= s_ge ? srem_sub[SREM_W-1:0] : srem_sh[SREM_W-1:0];
        root_q <= {root_q[ROOT_W-2:0], s_ge};
      end
      OP_DIV: begin
        drem_q <= d_ge ? drem_sub[COUNT_W-1:0] : drem_sh[COUNT_W-1:0];
        root_q <= {root_q[ROOT_W-2:0], d_ge};
      end
      OP_NONE, OP_LOAD: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (cmd_i.op == OP_DIFF) begin
      step_q <= '0;
    end else if (cmd_i.op == OP_SQRT || cmd_i.op == OP_DIV) begin
      step_q <= step_done ? '0 : step_q + STEP_W'(1);
    end
  end

  // output register
  logic             out_valid_q;
  psd_out_t         out_q;
  logic [STD_W-1:0] sd_sat;

  assign sd_sat = (|root_q[ROOT_W-1:STD_W]) ? STD_MAX : root_q[STD_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == OP_LOAD) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LOAD) begin
      out_q.std_dev      <= sd_sat;
      out_q.sample_count <= total_q;
      out_q.overflowed   <= ovf_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;
  assign sts_o.step_done = step_done;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= MAX_COUNT)
    else $error("sample count above limit");

  a_ovf_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (total_q == MAX_COUNT))
    else $error("overflow flagged below the count limit");

  a_sqrt_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_SQRT) |-> (srem_q <= SREM_W'({root_q, 1'b0})))
    else $error("root remainder out of range");

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_DIV) |-> (drem_q < total_q))
    else $error("divider remainder not below divisor");

endmodule

@@ rtl/population_std_dev.sv @@
`timescale 1ns / 1ps
// population_std_dev: top level, population standard deviation of a sample run.
// Depends on psd_pkg, psd_ctrl, psd_dp.
//
//   channel | signals                          | carries
//   --------+----------------------------------+-------------------------------
//   in      | in_valid_i, in_stall_o, in_data_i  | one sample, last marks run end
//   out     | out_valid_o, out_stall_i, out_data_o | std_dev, sample_count, overflow
//
// Cycles: samples transfer one per cycle while a run is open. The sample
// marked last raises in_stall_o, which stays high while the sequencer folds
// that sample in, runs the shared 32x32 multiplier and the subtract, the
// two-bits-per-step square root and the one-bit-per-step divide by n,
// then loads the output register once that register is free.
// Reset: asynchronous, active low; clears the count, sums, overflow flag,
// sequencer and output valid.
// Stalls: a result waiting in the output register does not hold up the next
// run; only a second result finding that register still full waits for it.
module population_std_dev
  import psd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  psd_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output psd_out_t out_data_o
);

  psd_cmd_t cmd;
  psd_sts_t sts;

  // sequencer: opens/closes runs, steps the final arithmetic
  psd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_data_i.last),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // accumulators, multiplier, root, divider and output register
  psd_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// tb: self-checking bench for population_std_dev, sample runs driven with random gaps
// and output stalls, each result checked against an in-bench exact-integer model.
// Depends on psd_pkg and the population_std_dev RTL.
module tb;
  import psd_pkg::*;

  localparam int unsigned ITEMS_PER_PHASE = 282;

  // Tracks the open run and queues the statistics each closing sample should produce.
  class std_dev_scoreboard;
    psd_out_t                pending_stats[$];
    logic [COUNT_W-1:0]      run_count;
    logic signed [SUM_W-1:0] run_sum;
    logic [SQSUM_W-1:0]      run_sq_sum;
    logic                    run_overflow;
    int unsigned             failures;

    function new();
      failures = 0;
      clear_run();
    endfunction

    function void clear_run();
      run_count    = '0;
      run_sum      = '0;
      run_sq_sum   = '0;
      run_overflow = 1'b0;
    endfunction

    // floor(isqrt((n*S2 - S1^2) * 4^F) / n), all in 128-bit integers
    function psd_out_t run_stats();
      logic [127:0] n;
      logic [127:0] mag;
      logic [127:0] radicand;
      logic [127:0] root;
      logic [127:0] cand;
      logic [127:0] quot;
      psd_out_t     res;
      n = 128'(run_count);
      if (run_sum < 0) mag = 128'(-run_sum);
      else mag = 128'(run_sum);
      if (n * 128'(run_sq_sum) > mag * mag)
        radicand = (n * 128'(run_sq_sum) - mag * mag) << (2 * FRAC_BITS);
      else
        radicand = '0;
      root = '0;
      for (int b = 63; b >= 0; b--) begin
        cand = root | (128'(1) << b);
        if (cand * cand <= radicand) root = cand;
      end
      quot = (n != 0) ? root / n : '0;
      if (quot > 128'(STD_MAX)) quot = 128'(STD_MAX);
      res.std_dev      = quot[STD_W-1:0];
      res.sample_count = run_count;
      res.overflowed   = run_overflow;
      return res;
    endfunction

    function void note_sample(psd_in_t item);
      logic signed [31:0] s;
      s = item.sample;
      // past the count limit samples are dropped but flagged
      if (run_count < MAX_COUNT) begin
        run_count  = run_count + COUNT_W'(1);
        run_sum    = run_sum + SUM_W'(s);
        run_sq_sum = run_sq_sum + SQSUM_W'(s * s);
      end else begin
        run_overflow = 1'b1;
      end
      if (item.last) begin
        pending_stats.push_back(run_stats());
        clear_run();
      end
    endfunction

    function void check_result(psd_out_t got);
      psd_out_t want;
      if (pending_stats.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result: std_dev=%0d count=%0d ovf=%0b",
                   got.std_dev, got.sample_count, got.overflowed);
        return;
      end
      want = pending_stats.pop_front();
      if (got.std_dev !== want.std_dev || got.sample_count !== want.sample_count ||
          got.overflowed !== want.overflowed) begin
        failures++;
        if (failures <= 10)
          $display({"mismatch: exp std_dev=%0d count=%0d ovf=%0b, ",
                    "got std_dev=%0d count=%0d ovf=%0b"},
                   want.std_dev, want.sample_count, want.overflowed,
                   got.std_dev, got.sample_count, got.overflowed);
      end
    endfunction
  endclass

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  psd_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  psd_out_t out_data_o;

  int unsigned       send_idle_pct = 0;
  int unsigned       stall_pct     = 0;
  std_dev_scoreboard stats_sb      = new();

  population_std_dev u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Everything is settled at the falling edge; a transfer seen here lands on the next rise.
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) stats_sb.check_result(out_data_o);
  end

  // Called just after a rising edge; returns just after the edge that took the transfer.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] value, input logic last);
    psd_in_t item;
    bit      taken;
    item.sample = value;
    item.last   = last;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      in_data_i  <= $bits(psd_in_t)'($urandom);
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    stats_sb.note_sample(item);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample(
      input int unsigned style, input logic signed [SAMPLE_W-1:0] centre);
    case (style)
      0: return SAMPLE_W'($urandom);
      1: begin
        case ($urandom_range(3))
          0: return 16'sh8000;
          1: return 16'sh7FFF;
          2: return 16'sh0000;
          default: return 16'shFFFF;
        endcase
      end
      // tight cluster round a random centre, wraps at the ends
      default: return centre + SAMPLE_W'($urandom_range(64)) - SAMPLE_W'(32);
    endcase
  endfunction

  task automatic random_runs(input int unsigned n_items);
    int unsigned                sent;
    int unsigned                len;
    int unsigned                run_style;
    logic signed [SAMPLE_W-1:0] centre;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(9))
        0:          len = 1;
        1, 2, 3, 4: len = $urandom_range(8, 2);
        default:    len = $urandom_range(40, 9);
      endcase
      run_style = $urandom_range(2);
      centre    = SAMPLE_W'($urandom);
      for (int unsigned k = 0; k < len; k++)
        send_sample(pick_sample(($urandom_range(9) == 0) ? 1 : run_style, centre),
                    k == len - 1);
      sent += len;
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // single-sample runs at both extremes
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh7FFF, 1'b1);
    // two extremes, widest two-sample spread
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7FFF, 1'b1);
    // flat runs give zero spread
    send_sample(16'sh0000, 1'b0);
    send_sample(16'sh0000, 1'b0);
    send_sample(16'sh0000, 1'b1);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh8000, 1'b1);
    // alternating bit patterns, small values, and both extremes with zero
    send_sample(16'sh5555, 1'b0);
    send_sample(16'shAAAA, 1'b0);
    send_sample(16'shFFFF, 1'b0);
    send_sample(16'sh0001, 1'b1);
    send_sample(16'sh0001, 1'b0);
    send_sample(16'shFFFF, 1'b0);
    send_sample(16'sh0001, 1'b0);
    send_sample(16'shFFFF, 1'b1);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh0000, 1'b0);
    send_sample(16'sh8000, 1'b1);

    random_runs(ITEMS_PER_PHASE);
    send_idle_pct = 78;
    random_runs(ITEMS_PER_PHASE);
    send_idle_pct = 0;
    stall_pct     = 78;
    random_runs(ITEMS_PER_PHASE);
    send_idle_pct = 8;
    stall_pct     = 8;
    random_runs(ITEMS_PER_PHASE);
    in_valid_i <= 1'b0;

    while (stats_sb.pending_stats.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
    if (stats_sb.failures == 0 && stats_sb.pending_stats.size() == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb failed");
    $finish;
  end

endmodule
